// ===== hdl/aes_pkg.sv =====
// Package: AES types, S-box tables and round helper functions.
package aes_pkg;

	localparam int NUM_RK_WORDS = 60;
	localparam int RK_AW = 6;
	localparam int RK_ROW_AW = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_0   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_1   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_3   = 3'd4;

	localparam logic REQ_ENC = 1'b0;
	localparam logic REQ_DEC = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [63:0] block_hi;
		logic [63:0] block_lo;
	} in_word_t;

	typedef struct packed {
		logic [63:0] result_hi;
		logic [63:0] result_lo;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_KEY0,
		ST_ROUND,
		ST_DONE
	} state_t;

	// control from sequencer to round datapath
	typedef struct packed {
		logic load;
		logic first;
		logic final_rnd;
		logic step;
		logic dec;
	} rnd_ctl_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
		logic [7:0] p, x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 4; i++) begin
			if (b[i])
				p = p ^ x;
			x = xtime(x);
		end
		gmul = p;
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] v);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		sbox = t[v];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] v);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		inv_sbox = t[v];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

endpackage

// ===== hdl/aes_key_exp.sv =====
// Key schedule: one round-key word per cycle into an internal memory.
module aes_key_exp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [1:0]                       key_len,
	input  logic [255:0]                     key,
	input  logic [aes_pkg::RK_ROW_AW-1:0]    rd_addr,
	output logic [127:0]                     rd_data,
	output logic                             busy
);
	import aes_pkg::*;

	logic [31:0]      mem0 [NUM_RK_WORDS/4];
	logic [31:0]      mem1 [NUM_RK_WORDS/4];
	logic [31:0]      mem2 [NUM_RK_WORDS/4];
	logic [31:0]      mem3 [NUM_RK_WORDS/4];
	logic [RK_AW-1:0] idx_q;
	logic [3:0]       mod_q;   // idx mod nk
	logic [7:0]       rcon_q;
	logic [31:0]      prev_q;
	logic [31:0]      win_q [8]; // last nk words in win_q[0..nk-1], win_q[nk-1] oldest-needed via shift
	logic [RK_AW-1:0] total;
	logic [3:0]       nk;
	logic [31:0]      t, nw, back;
	logic             in_key;

	assign nk    = (key_len == 2'd0) ? 4'd4 : (key_len == 2'd1) ? 4'd6 : 4'd8;
	assign total = (key_len == 2'd0) ? RK_AW'(44) : (key_len == 2'd1) ? RK_AW'(52) : RK_AW'(60);
	assign in_key = idx_q < RK_AW'(nk);
	assign back  = win_q[3'(nk - 4'd1)];

	always_comb begin
		t = prev_q;
		if (mod_q == 4'd0) begin
			t = sub_word(prev_q);
			t = {t[23:0], t[31:24]} ^ {rcon_q, 24'h0};
		end else if (nk == 4'd8 && mod_q == 4'd4) begin
			t = sub_word(prev_q);
		end
		if (in_key)
			nw = key[255 - 32*idx_q[2:0] -: 32];
		else
			nw = back ^ t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy   <= 1'b0;
			idx_q  <= '0;
			mod_q  <= '0;
			rcon_q <= 8'h01;
		end else if (start) begin
			busy   <= 1'b1;
			idx_q  <= '0;
			mod_q  <= '0;
			rcon_q <= 8'h01;
		end else if (busy) begin
			idx_q <= idx_q + RK_AW'(1);
			mod_q <= (mod_q == nk - 4'd1) ? 4'd0 : mod_q + 4'd1;
			if (!in_key && mod_q == 4'd0)
				rcon_q <= xtime(rcon_q);
			if (idx_q == total - RK_AW'(1))
				busy <= 1'b0;
		end
	end

	// word window and memory writes
	always_ff @(posedge clk) begin
		if (busy) begin
			prev_q <= nw;
			win_q[0] <= nw;
			for (int i = 1; i < 8; i++)
				win_q[i] <= win_q[i-1];
			case (idx_q[1:0])
				2'd0: mem0[idx_q[RK_AW-1:2]] <= nw;
				2'd1: mem1[idx_q[RK_AW-1:2]] <= nw;
				2'd2: mem2[idx_q[RK_AW-1:2]] <= nw;
				default: mem3[idx_q[RK_AW-1:2]] <= nw;
			endcase
		end
		rd_data <= {mem0[rd_addr], mem1[rd_addr], mem2[rd_addr], mem3[rd_addr]};
	end

endmodule

// ===== hdl/aes_round.sv =====
// Shared round datapath: one AES round (either direction) per cycle while step is set.
module aes_round (
	input  logic              clk,
	input  aes_pkg::rnd_ctl_t ctl,
	input  logic [127:0]      blk_in,
	input  logic [127:0]      rkey,
	output logic [127:0]      state
);
	import aes_pkg::*;

	logic [127:0] state_q, sb, mc, nxt;
	logic [7:0]   s [16];
	logic [7:0]   a [16];
	logic [7:0]   b [16];
	logic [7:0]   m [16];

	always_comb begin
		for (int i = 0; i < 16; i++)
			s[i] = state_q[127 - 8*i -: 8];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				if (ctl.dec)
					a[r + 4*c] = s[r + 4*((c + 4 - r) & 3)];
				else
					a[r + 4*c] = s[r + 4*((c + r) & 3)];
			end
		for (int i = 0; i < 16; i++)
			b[i] = ctl.dec ? inv_sbox(a[i]) : sbox(a[i]);
		for (int i = 0; i < 16; i++)
			sb[127 - 8*i -: 8] = b[i] ^ rkey[127 - 8*i -: 8];
		// encrypt: sub/shift, mix, addkey. decrypt: shift/sub, addkey, invmix
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				if (ctl.dec)
					m[4*c + r] = gmul(sb[127 - 8*(4*c + r) -: 8], 4'he)
						^ gmul(sb[127 - 8*(4*c + ((r+1)&3)) -: 8], 4'hb)
						^ gmul(sb[127 - 8*(4*c + ((r+2)&3)) -: 8], 4'hd)
						^ gmul(sb[127 - 8*(4*c + ((r+3)&3)) -: 8], 4'h9);
				else
					m[4*c + r] = gmul(b[4*c + r], 4'h2)
						^ gmul(b[4*c + ((r+1)&3)], 4'h3)
						^ b[4*c + ((r+2)&3)] ^ b[4*c + ((r+3)&3)];
			end
		for (int i = 0; i < 16; i++)
			mc[127 - 8*i -: 8] = ctl.dec ? m[i] : (m[i] ^ rkey[127 - 8*i -: 8]);
		if (ctl.first)
			nxt = blk_in ^ rkey;
		else if (ctl.final_rnd)
			nxt = sb;
		else
			nxt = mc;
	end

	assign state = state_q;

	always_ff @(posedge clk) begin
		if (ctl.load)
			state_q <= blk_in;
		else if (ctl.step)
			state_q <= (ctl.first ? state_q ^ rkey : nxt);
	end

endmodule

// ===== hdl/aes_block_cipher.sv =====
// Top level: AES-128/192/256 ECB cipher with sequencer and output register.
//  channel | valid     | ready     | payload
//  in      | in_valid  | in_ready  | in_data  (aes_pkg::in_word_t)
//  out     | out_valid | out_ready | out_data (aes_pkg::out_word_t)
//  cfg     | cfg_we    | -         | cfg_idx, cfg_data
// Each word: key expansion (one schedule word per cycle, 44/52/60 words), then the
// initial key add, Nr rounds (10/12/14) on the shared round unit, and a load of the
// output register together with out_valid.
// in_ready is high only when idle with the output register free; with out_ready high
// the next word is taken once out_valid has dropped, so words never overlap.
// The result sits in the output register until taken; out_ready stalls hold it.
// Reset clears control and configuration; the key memory needs no clearing.
module aes_block_cipher (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  aes_pkg::in_word_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output aes_pkg::out_word_t                out_data,
	input  logic                              cfg_we,
	input  logic [aes_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [aes_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import aes_pkg::*;

	state_t        st_q, st_d;
	logic [1:0]    klen_q;
	logic [63:0]   key_q [4];
	logic          dec_q;
	logic [127:0]  blk_q;
	logic [3:0]    rnd_q;   // current round number
	logic [3:0]    nr;
	logic          kx_start, kx_busy;
	logic [RK_ROW_AW-1:0] rk_addr;
	logic [127:0]  rk_data, rnd_state;
	rnd_ctl_t      ctl;
	logic [1:0]    klen_eff;

	assign klen_eff = (klen_q == 2'd3) ? 2'd2 : klen_q;
	assign nr = 4'd10 + {1'b0, klen_eff, 1'b0};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= '0;
			for (int i = 0; i < 4; i++)
				key_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_KEY_LEN: klen_q   <= cfg_data[1:0];
				REG_KEY_0:   key_q[0] <= cfg_data;
				REG_KEY_1:   key_q[1] <= cfg_data;
				REG_KEY_2:   key_q[2] <= cfg_data;
				REG_KEY_3:   key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	aes_key_exp u_kx (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (kx_start),
		.key_len (klen_eff),
		.key     ({key_q[0], key_q[1], key_q[2], key_q[3]}),
		.rd_addr (rk_addr),
		.rd_data (rk_data),
		.busy    (kx_busy)
	);

	aes_round u_rnd (
		.clk    (clk),
		.ctl    (ctl),
		.blk_in (blk_q),
		.rkey   (rk_data),
		.state  (rnd_state)
	);

	// round key row address; read data is registered, so in KEY0 and ROUND the address is the next round's row
	always_comb begin
		logic [3:0] nxt_rnd;
		nxt_rnd = (st_q == ST_ROUND || st_q == ST_KEY0) ?
			(dec_q ? rnd_q - 4'd1 : rnd_q + 4'd1) : rnd_q;
		rk_addr = nxt_rnd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			rnd_q <= '0;
			out_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (st_q)
				ST_EXPAND: rnd_q <= dec_q ? nr : 4'd0;
				ST_KEY0:   rnd_q <= dec_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
				ST_ROUND:  rnd_q <= dec_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
				default: ;
			endcase
			if (st_q == ST_DONE)
				out_valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dec_q <= in_data.req_type;
			blk_q <= {in_data.block_hi, in_data.block_lo};
		end
		if (st_q == ST_DONE)
			out_data <= rnd_state;
	end

	// sequencer: EXPAND waits for schedule, KEY0 adds first key, ROUND runs Nr
	always_comb begin
		st_d     = st_q;
		in_ready = 1'b0;
		kx_start = 1'b0;
		ctl      = '0;
		ctl.dec  = dec_q;
		case (st_q)
			ST_IDLE: begin
				in_ready = !out_valid;
				if (in_valid && !out_valid) begin
					kx_start = 1'b1;
					st_d = ST_EXPAND;
				end
			end
			ST_EXPAND: begin
				ctl.load = 1'b1;
				if (!kx_busy)
					st_d = ST_KEY0;
			end
			ST_KEY0: begin
				ctl.step  = 1'b1;
				ctl.first = 1'b1;
				st_d = ST_ROUND;
			end
			ST_ROUND: begin
				ctl.step = 1'b1;
				ctl.final_rnd = dec_q ? (rnd_q == 4'd0) : (rnd_q == nr);
				if (ctl.final_rnd)
					st_d = ST_DONE;
			end
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !in_ready)
		else $error("input taken while busy");
	a_done_sets_out: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE) |=> out_valid)
		else $error("result not presented");
	a_kx_before_round: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ROUND) |-> !kx_busy)
		else $error("round with schedule busy");
`endif

endmodule
